@@ design/qdcd_pkg.sv @@
// ----------------------------------------------------------------------------
// qdcd_pkg
// Shared codes, widths and types of the quantized delta channel decoder.
// ----------------------------------------------------------------------------
package qdcd_pkg;

    // Item opcodes.
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_DELTA   = 2'd2;

    // Delta width modes.
    localparam logic [1:0] MODE_NIB  = 2'd0;
    localparam logic [1:0] MODE_BYTE = 2'd1;
    localparam logic [1:0] MODE_WORD = 2'd2;

    // Configuration register indexes and port widths.
    localparam int         REG_IDX_W         = 1;
    localparam int         CFG_DATA_W        = 7;
    localparam logic [0:0] REG_QUANT_MODE    = 1'b0;
    localparam logic [0:0] REG_CHANNEL_COUNT = 1'b1;

    // Register reset values.
    localparam logic [1:0] QUANT_MODE_RST    = MODE_BYTE;
    localparam logic [6:0] CHANNEL_COUNT_RST = 7'd1;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    // Work handed to one lane for the current beat.
    typedef struct packed {
        logic        upd;
        logic        load;
        logic        restart;
        logic        last;
        logic [5:0]  chan;
        logic [15:0] q;
    } lane_ctl_t;

    // One decoded channel value leaving a lane.
    typedef struct packed {
        logic               valid;
        logic [5:0]         chan;
        logic signed [31:0] value;
        logic               last;
    } lane_res_t;

endpackage

@@ design/qdcd_item_if.sv @@
// ----------------------------------------------------------------------------
// qdcd_item_if
// Input channel of the decoder: table loads, restarts and delta beats.
// ----------------------------------------------------------------------------
interface qdcd_item_if;

    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [5:0]         table_index;
    logic signed [31:0] start_value;
    logic signed [31:0] quant_step;
    logic signed [31:0] quant_offset;
    logic [15:0]        delta_data;

    modport source (
        output valid, opcode, table_index, start_value, quant_step, quant_offset,
               delta_data,
        input  ready
    );

    modport sink (
        input  valid, opcode, table_index, start_value, quant_step, quant_offset,
               delta_data,
        output ready
    );

endinterface

@@ design/qdcd_result_if.sv @@
// ----------------------------------------------------------------------------
// qdcd_result_if
// Output channel of the decoder: one updated channel value per beat.
// ----------------------------------------------------------------------------
interface qdcd_result_if;

    logic               valid;
    logic               ready;
    logic [5:0]         channel;
    logic signed [31:0] channel_value;
    logic               frame_last;

    modport source (
        output valid, channel, channel_value, frame_last,
        input  ready
    );

    modport sink (
        input  valid, channel, channel_value, frame_last,
        output ready
    );

endinterface

@@ design/qdcd_ram.sv @@
// ----------------------------------------------------------------------------
// qdcd_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module qdcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read at the written address returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ design/qdcd_lane.sv @@
// ----------------------------------------------------------------------------
// qdcd_lane
// One channel bank: table and accumulator storage plus the multiply-add
// and saturation for the channels of one parity.
// ----------------------------------------------------------------------------
module qdcd_lane #(
    parameter int BANK_DEPTH = 32,
    localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  qdcd_pkg::lane_ctl_t ctl,
    input  logic [AW-1:0]       addr,
    input  logic signed [31:0]  start_value,
    input  logic signed [31:0]  quant_step,
    input  logic signed [31:0]  quant_offset,
    output qdcd_pkg::lane_res_t res
);

    import qdcd_pkg::*;

    localparam logic signed [50:0] SAT_MAX = 51'sd2147483647;
    localparam logic signed [50:0] SAT_MIN = -51'sd2147483648;

    // Stage 1 and stage 2 registers.
    lane_ctl_t          s1_ctl_reg;
    logic [AW-1:0]      s1_addr_reg;
    lane_ctl_t          s2_ctl_reg;
    logic [AW-1:0]      s2_addr_reg;
    logic signed [48:0] s2_prod_reg;
    logic signed [31:0] s2_off_reg;
    logic signed [31:0] s2_start_reg;

    // Accumulator state kept in flip-flops.
    logic [BANK_DEPTH-1:0] vld_reg;
    logic [BANK_DEPTH-1:0] vld_next;
    logic                  restarted_reg;
    logic                  fw_v_reg;
    logic [AW-1:0]         fw_addr_reg;
    logic signed [31:0]    fw_data_reg;

    logic [95:0]        tbl_rd;
    logic signed [31:0] tbl_start;
    logic signed [31:0] tbl_step;
    logic signed [31:0] tbl_off;
    logic signed [48:0] prod;
    logic [31:0]        acc_rd;
    logic signed [31:0] acc_cur;
    logic signed [31:0] acc_base;
    logic signed [50:0] sum;
    logic signed [31:0] sat;
    logic               acc_we;
    logic signed [31:0] acc_wd;

    // Table entry: start, step and offset side by side. A load reads the old
    // start value in the same beat, so it can be kept if the channel still
    // holds its restart value.
    qdcd_ram #(
        .WIDTH (96),
        .DEPTH (BANK_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ctl.load),
        .wr_addr (addr),
        .wr_data ({start_value, quant_step, quant_offset}),
        .rd_addr (addr),
        .rd_data (tbl_rd)
    );

    assign tbl_start = $signed(tbl_rd[95:64]);
    assign tbl_step  = $signed(tbl_rd[63:32]);
    assign tbl_off   = $signed(tbl_rd[31:0]);

    // Stage 1: quantized delta times step.
    assign prod = $signed({1'b0, s1_ctl_reg.q}) * tbl_step;

    // Accumulator values, read in stage 1 and written back in stage 2.
    qdcd_ram #(
        .WIDTH (32),
        .DEPTH (BANK_DEPTH)
    ) u_acc (
        .clk     (clk),
        .wr_en   (acc_we),
        .wr_addr (s2_addr_reg),
        .wr_data (acc_wd),
        .rd_addr (s1_addr_reg),
        .rd_data (acc_rd)
    );

    // Stage 2: pick up the newest accumulator value. The write of the beat
    // just ahead is not yet visible in the RAM read, so it is forwarded.
    // An entry not written since reset reads zero, and one not written since
    // the last restart reads its start value.
    always_comb
    begin
        if (fw_v_reg && (fw_addr_reg == s2_addr_reg))
        begin
            acc_cur = fw_data_reg;
        end
        else
        begin
            acc_cur = $signed(acc_rd);
        end

        if (vld_reg[s2_addr_reg])
        begin
            acc_base = acc_cur;
        end
        else if (restarted_reg)
        begin
            acc_base = s2_start_reg;
        end
        else
        begin
            acc_base = '0;
        end
    end

    // Exact sum, then saturate to 32 bits.
    assign sum = 51'(acc_base) + 51'(s2_prod_reg) + 51'(s2_off_reg);

    always_comb
    begin
        if (sum > SAT_MAX)
        begin
            sat = 32'sh7fffffff;
        end
        else if (sum < SAT_MIN)
        begin
            sat = 32'sh80000000;
        end
        else
        begin
            sat = sum[31:0];
        end
    end

    // A delta writes its new value. A load over a channel that still holds
    // its restart value stores that value first, so the new start value
    // does not leak into the running accumulator.
    assign acc_we = s2_ctl_reg.upd ||
                    (s2_ctl_reg.load && !vld_reg[s2_addr_reg] && restarted_reg);
    assign acc_wd = s2_ctl_reg.upd ? sat : s2_start_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (s2_ctl_reg.restart)
        begin
            vld_next = '0;
        end
        else if (acc_we)
        begin
            vld_next[s2_addr_reg] = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg    <= '0;
            s2_ctl_reg    <= '0;
            vld_reg       <= '0;
            restarted_reg <= 1'b0;
            fw_v_reg      <= 1'b0;
        end
        else
        begin
            s1_ctl_reg <= ctl;
            s2_ctl_reg <= s1_ctl_reg;
            vld_reg    <= vld_next;
            fw_v_reg   <= acc_we;
            if (s2_ctl_reg.restart)
            begin
                restarted_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        s1_addr_reg  <= addr;
        s2_addr_reg  <= s1_addr_reg;
        s2_prod_reg  <= prod;
        s2_off_reg   <= tbl_off;
        s2_start_reg <= tbl_start;
        fw_addr_reg  <= s2_addr_reg;
        fw_data_reg  <= acc_wd;
    end

    // Result of this lane for the beat in stage 2.
    always_comb
    begin
        res.valid = s2_ctl_reg.upd;
        res.chan  = s2_ctl_reg.chan;
        res.value = sat;
        res.last  = s2_ctl_reg.last;
    end

endmodule

@@ design/qdcd_merge.sv @@
// ----------------------------------------------------------------------------
// qdcd_merge
// Puts the results of the two lanes in channel order and queues them for
// the output channel, one result per beat.
// ----------------------------------------------------------------------------
module qdcd_merge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  qdcd_pkg::lane_res_t         res_even,
    input  qdcd_pkg::lane_res_t         res_odd,
    input  logic                        odd_first,
    qdcd_result_if.source               results,
    output logic [qdcd_pkg::FIFO_CW-1:0] fill
);

    import qdcd_pkg::*;

    lane_res_t            fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg;
    logic [FIFO_CW-1:0]   count_next;
    lane_res_t            first;
    lane_res_t            second;
    logic [FIFO_AW-1:0]   second_ptr;
    logic [1:0]           n_push;
    logic                 pop;

    // The lower channel of a beat goes first.
    assign first      = odd_first ? res_odd : res_even;
    assign second     = odd_first ? res_even : res_odd;
    assign second_ptr = first.valid ? (wr_ptr_reg + FIFO_AW'(1)) : wr_ptr_reg;
    assign n_push     = 2'(first.valid) + 2'(second.valid);
    assign pop        = results.valid && results.ready;

    assign wr_ptr_next = wr_ptr_reg + FIFO_AW'(n_push);
    assign rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
    assign count_next  = count_reg + FIFO_CW'(n_push) - FIFO_CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (first.valid)
        begin
            fifo_reg[wr_ptr_reg] <= first;
        end
        if (second.valid)
        begin
            fifo_reg[second_ptr] <= second;
        end
    end

    // Head of the queue drives the output beat.
    assign results.valid         = (count_reg != '0);
    assign results.channel       = fifo_reg[rd_ptr_reg].chan;
    assign results.channel_value = fifo_reg[rd_ptr_reg].value;
    assign results.frame_last    = fifo_reg[rd_ptr_reg].last;
    assign fill                  = count_reg;

endmodule

@@ design/quantized_delta_channel_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// quantized_delta_channel_decoder_unit
// Decodes animation channels stored as quantized per-frame deltas.
// ----------------------------------------------------------------------------
// An input beat is taken every cycle as long as the 8-entry result queue has
// room for everything in flight; the first result of a delta beat passes the
// lane stage 1 and stage 2 registers and the result queue before it appears.
// In 8-bit and 16-bit mode the block sustains one item per cycle while the
// queue has room. In packed 4-bit mode an item yields two results and the
// single result port delivers one per cycle, which then sets the pace. Even
// and odd channels live in two lanes, each with its own table and accumulator
// RAMs and one 17x32 multiplier, so both nibbles of a beat are decoded
// together. Restart takes one beat: per-entry valid bits mark accumulators
// that still hold their start value, and no clearing pass runs after reset.
module quantized_delta_channel_decoder_unit #(
    parameter int MAX_CHANNELS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    qdcd_item_if.sink                         items,
    qdcd_result_if.source                     results,
    input  logic                              cfg_we,
    input  logic [qdcd_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [qdcd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import qdcd_pkg::*;

    localparam int CLOG_MAX   = $clog2(MAX_CHANNELS + 1);
    localparam int CW         = (CLOG_MAX > CFG_DATA_W) ? CLOG_MAX : CFG_DATA_W;
    localparam int EW         = CW + 1;
    localparam int IDX_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int BANK_DEPTH = (MAX_CHANNELS + 1) / 2;
    localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    // Configuration and frame position.
    logic [1:0]            quant_mode_reg;
    logic [CFG_DATA_W-1:0] channel_count_reg;
    logic [IDX_W-1:0]      next_ch_reg;
    logic [IDX_W-1:0]      next_ch_next;

    // Result bookkeeping for the beats inside the lanes.
    logic [1:0] n1_reg;
    logic [1:0] n2_reg;
    logic       odd1_reg;
    logic       odd2_reg;
    logic [1:0] n_res;

    logic [EW-1:0] cnt;
    logic [EW-1:0] cur;
    logic [EW-1:0] ch;
    logic [EW-1:0] ch1;
    logic [EW-1:0] ch2;
    logic [EW-1:0] tix;
    logic          tix_ok;
    logic          accept;
    logic          is_delta;
    logic          two;
    logic [15:0]   q0;
    logic [15:0]   q1;

    logic [FIFO_CW-1:0] fill;
    lane_ctl_t          lane_ctl  [2];
    logic [BA_W-1:0]    lane_addr [2];
    lane_res_t          lane_res  [2];

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quant_mode_reg    <= QUANT_MODE_RST;
            channel_count_reg <= CHANNEL_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_QUANT_MODE:    quant_mode_reg    <= cfg_data[1:0];
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Effective channel count, clamped to 1..MAX_CHANNELS.
    always_comb
    begin
        cnt = EW'(channel_count_reg);
        if (cnt == '0)
        begin
            cnt = EW'(1);
        end
        else if (cnt > EW'(MAX_CHANNELS))
        begin
            cnt = EW'(MAX_CHANNELS);
        end
    end

    // Channel for this beat; a shrunken count restarts the frame.
    assign cur = EW'(next_ch_reg);
    assign ch  = (cur >= cnt) ? '0 : cur;
    assign ch1 = ch + EW'(1);
    assign ch2 = ch + EW'(2);

    assign accept   = items.valid && items.ready;
    assign is_delta = accept && (items.opcode == OP_DELTA) &&
                      ((quant_mode_reg == MODE_NIB) || (quant_mode_reg == MODE_BYTE) ||
                       (quant_mode_reg == MODE_WORD));
    // In packed mode the high nibble is padding when the low one ends the frame.
    assign two      = (quant_mode_reg == MODE_NIB) && (ch1 < cnt);

    always_comb
    begin
        case (quant_mode_reg)
            MODE_WORD: q0 = items.delta_data;
            MODE_BYTE: q0 = {8'd0, items.delta_data[7:0]};
            default:   q0 = {12'd0, items.delta_data[3:0]};
        endcase
    end
    assign q1 = {12'd0, items.delta_data[7:4]};

    assign tix    = EW'(items.table_index);
    assign tix_ok = (tix < EW'(MAX_CHANNELS));

    // Frame position update.
    always_comb
    begin
        next_ch_next = next_ch_reg;
        if (accept && (items.opcode == OP_RESTART))
        begin
            next_ch_next = '0;
        end
        else if (is_delta)
        begin
            if (two)
            begin
                next_ch_next = (ch2 >= cnt) ? '0 : IDX_W'(ch2);
            end
            else
            begin
                next_ch_next = (ch1 >= cnt) ? '0 : IDX_W'(ch1);
            end
        end
    end

    assign n_res = is_delta ? (two ? 2'd2 : 2'd1) : 2'd0;

    // Lane 0 holds even channels and lane 1 odd ones.
    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic first_here;

        assign first_here = (ch[0] == 1'(l));

        always_comb
        begin
            lane_ctl[l].upd     = is_delta && (first_here || two);
            lane_ctl[l].load    = accept && (items.opcode == OP_LOAD) && tix_ok &&
                                  (tix[0] == 1'(l));
            lane_ctl[l].restart = accept && (items.opcode == OP_RESTART);
            lane_ctl[l].q       = first_here ? q0 : q1;
            lane_ctl[l].chan    = first_here ? ch[5:0] : ch1[5:0];
            lane_ctl[l].last    = first_here ? (ch1 == cnt) : (ch2 == cnt);
            if (accept && (items.opcode == OP_LOAD))
            begin
                lane_addr[l] = tix[BA_W:1];
            end
            else
            begin
                lane_addr[l] = first_here ? ch[BA_W:1] : ch1[BA_W:1];
            end
        end

        qdcd_lane #(
            .BANK_DEPTH (BANK_DEPTH)
        ) u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (lane_ctl[l]),
            .addr         (lane_addr[l]),
            .start_value  (items.start_value),
            .quant_step   (items.quant_step),
            .quant_offset (items.quant_offset),
            .res          (lane_res[l])
        );
    end

    // Track results in flight and which lane holds the lower channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_ch_reg <= '0;
            n1_reg      <= '0;
            n2_reg      <= '0;
            odd1_reg    <= 1'b0;
            odd2_reg    <= 1'b0;
        end
        else
        begin
            next_ch_reg <= next_ch_next;
            n1_reg      <= n_res;
            n2_reg      <= n1_reg;
            odd1_reg    <= ch[0];
            odd2_reg    <= odd1_reg;
        end
    end

    // Take a beat only if the queue can absorb every result it may cause.
    assign items.ready = ((5'(fill) + 5'(n1_reg) + 5'(n2_reg) + 5'd2) <= 5'(FIFO_DEPTH));

    qdcd_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_even  (lane_res[0]),
        .res_odd   (lane_res[1]),
        .odd_first (odd2_reg),
        .results   (results),
        .fill      (fill)
    );

endmodule
